// File: hdl/glp_pkg.sv
package glp_pkg;

    // line buffer length and number of fraction digits kept
    localparam int LINE_BUF    = 64;
    localparam int FRAC_DIGITS = 3;

    localparam int CNT_W  = $clog2(LINE_BUF);
    localparam int FCNT_W = 3;
    localparam int CODE_W = 14;
    localparam int MAG_W  = 32;
    localparam int VAL_W  = 32;

    localparam int TDATA_W = 104;

    localparam logic [CODE_W-1:0] CODE_MAX = 14'd16383;
    localparam logic [MAG_W-1:0]  MAG_MAX  = 32'h7fff_ffff;

    // code numbers that mean something
    localparam logic [CODE_W-1:0] G_MOVE  = 14'd1;
    localparam logic [CODE_W-1:0] G_HOME  = 14'd28;
    localparam logic [CODE_W-1:0] M_RESET = 14'd999;

    // command types
    localparam logic [1:0] CMD_NONE  = 2'd0;
    localparam logic [1:0] CMD_MOVE  = 2'd1;
    localparam logic [1:0] CMD_HOME  = 2'd2;
    localparam logic [1:0] CMD_RESET = 2'd3;

    // axis selects
    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_F = 2'd2;

    // characters
    localparam logic [7:0] CH_NUL   = 8'd0;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_DOT   = 8'h2e;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_F     = 8'h46;
    localparam logic [7:0] CH_G     = 8'h47;
    localparam logic [7:0] CH_M     = 8'h4d;
    localparam logic [7:0] CH_X     = 8'h58;
    localparam logic [7:0] CH_Y     = 8'h59;

    // scan state
    typedef enum logic [6:0] {
        MODE_BETWEEN   = 7'b0000001,
        MODE_CODE_G    = 7'b0000010,
        MODE_CODE_M    = 7'b0000100,
        MODE_NUM_START = 7'b0001000,
        MODE_NUM_INT   = 7'b0010000,
        MODE_NUM_FRAC  = 7'b0100000,
        MODE_STOPPED   = 7'b1000000
    } mode_t;

    // one command, laid out as on the output bus, lowest field last
    typedef struct packed {
        logic [2:0]       pad;
        logic [VAL_W-1:0] feed_value;
        logic             f_valid;
        logic [VAL_W-1:0] y_value;
        logic             y_valid;
        logic [VAL_W-1:0] x_value;
        logic             x_valid;
        logic [1:0]       cmd_type;
    } cmd_t;

    typedef logic [7:0][MAG_W-1:0] scale_tab_t;

    function automatic logic [MAG_W-1:0] pow10(int n);
        logic [MAG_W-1:0] p;
        p = 1;
        for (int k = 0; k < n; k++)
        begin
            p = MAG_W'(p * 10);
        end
        return p;
    endfunction

    // weight of each fraction digit, zero past the kept digits
    function automatic scale_tab_t make_frac_tab();
        scale_tab_t t;
        for (int k = 0; k < 8; k++)
        begin
            t[k] = (k < FRAC_DIGITS) ? pow10(FRAC_DIGITS - 1 - k) : '0;
        end
        return t;
    endfunction

    localparam logic [MAG_W-1:0] INT_SCALE  = pow10(FRAC_DIGITS);
    localparam scale_tab_t       FRAC_SCALE = make_frac_tab();

endpackage

// File: hdl/gcode_line_parser.sv
// G-code line parser. One received character enters per beat on the s_ side, and a new
// beat can be taken in every clock cycle while s_tready is high: each character updates
// the running parse state in the same cycle it is accepted. When a CR or LF closes a
// non-empty line, the decoded command (G1, G28, M999 or none, with X, Y and F in fixed
// point thousandths) is registered into the result register that drives the m_ side, or
// into the skid entry while that register is stalled. s_tready drops only while both
// are full, so a stalled consumer holds back input after at most one further command.
// G1 lines fill missing X and Y from the previous command, every line fills a missing F.
// Past LINE_BUF-1 characters, what a line has parsed so far is dropped without a result.
module gcode_line_parser (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [7:0]                   s_tdata,   // rx_byte[7:0]
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // cmd_type[1:0], x_valid[2], x_value[34:3], y_valid[35], y_value[67:36],
    // f_valid[68], feed_value[100:69], zero pad[103:101]
    output logic [glp_pkg::TDATA_W-1:0] m_tdata
);
    import glp_pkg::*;

    // parse state
    mode_t              mode_reg, mode_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CODE_W-1:0]  code_reg, code_next;
    logic [MAG_W-1:0]   mag_reg, mag_next;
    logic [FCNT_W-1:0]  fcnt_reg, fcnt_next;
    logic               neg_reg, neg_next;
    logic [1:0]         axis_reg, axis_next;
    logic [1:0]         type_reg, type_next;
    logic               lx_v_reg, lx_v_next, ly_v_reg, ly_v_next, lf_v_reg, lf_v_next;
    logic [VAL_W-1:0]   lx_reg, lx_next, ly_reg, ly_next, lf_reg, lf_next;
    logic               px_v_reg, px_v_next, py_v_reg, py_v_next, pf_v_reg, pf_v_next;
    logic [VAL_W-1:0]   px_reg, px_next, py_reg, py_next, pf_reg, pf_next;

    // output stage
    cmd_t out_reg, out_next, skid_reg, skid_next;
    logic out_valid_reg, out_valid_next, skid_valid_reg, skid_valid_next;

    // pending item completed
    mode_t             fin_mode;
    logic [1:0]        fin_type;
    logic              fin_x_v, fin_y_v, fin_f_v;
    logic [VAL_W-1:0]  fin_x, fin_y, fin_f, num_val;

    logic              accept, is_digit, take_fin;
    logic [7:0]        c;
    logic [3:0]        digit;
    logic [17:0]       code_sum;
    logic [MAG_W+3:0]  int_sum, frac_sum;
    cmd_t              res;
    logic              res_valid;
    logic              cx_v, cy_v, cf_v;
    logic [VAL_W-1:0]  cx, cy, cf;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = !skid_valid_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;
    assign c        = s_tdata;

    // completion of the pending code or number
    always_comb
    begin
        fin_mode = mode_reg;
        fin_type = type_reg;
        fin_x_v  = lx_v_reg;
        fin_x    = lx_reg;
        fin_y_v  = ly_v_reg;
        fin_y    = ly_reg;
        fin_f_v  = lf_v_reg;
        fin_f    = lf_reg;
        num_val  = neg_reg ? VAL_W'(-mag_reg) : mag_reg;
        case (mode_reg)
            MODE_CODE_G:
            begin
                if (code_reg == G_MOVE)
                begin
                    fin_type = CMD_MOVE;
                    fin_mode = MODE_BETWEEN;
                end
                else if (code_reg == G_HOME)
                begin
                    fin_type = CMD_HOME;
                    fin_mode = MODE_BETWEEN;
                end
                else
                begin
                    fin_mode = MODE_STOPPED;
                end
            end
            MODE_CODE_M:
            begin
                if (code_reg == M_RESET)
                begin
                    fin_type = CMD_RESET;
                end
                fin_mode = MODE_BETWEEN;
            end
            MODE_NUM_START, MODE_NUM_INT, MODE_NUM_FRAC:
            begin
                case (axis_reg)
                    AXIS_X:
                    begin
                        fin_x_v = 1'b1;
                        fin_x   = num_val;
                    end
                    AXIS_Y:
                    begin
                        fin_y_v = 1'b1;
                        fin_y   = num_val;
                    end
                    default:
                    begin
                        fin_f_v = 1'b1;
                        fin_f   = num_val;
                    end
                endcase
                fin_mode = MODE_BETWEEN;
            end
            default:
            begin
            end
        endcase
    end

    // digit arithmetic with saturation
    always_comb
    begin
        is_digit = c inside {[CH_ZERO:CH_NINE]};
        digit    = is_digit ? 4'(c - CH_ZERO) : 4'd0;
        code_sum = 18'(code_reg) * 18'd10 + 18'(digit);
        int_sum  = (MAG_W+4)'(mag_reg) * (MAG_W+4)'(10)
                 + (MAG_W+4)'(digit) * (MAG_W+4)'(INT_SCALE);
        frac_sum = (MAG_W+4)'(mag_reg)
                 + (MAG_W+4)'(digit) * (MAG_W+4)'(FRAC_SCALE[fcnt_reg]);
    end

    // command at line end, with fills from the previous command
    always_comb
    begin
        cx_v = fin_x_v;
        cx   = fin_x;
        cy_v = fin_y_v;
        cy   = fin_y;
        cf_v = fin_f_v;
        cf   = fin_f;
        if (fin_type == CMD_MOVE && !fin_x_v)
        begin
            cx_v = px_v_reg;
            cx   = px_reg;
        end
        if (fin_type == CMD_MOVE && !fin_y_v)
        begin
            cy_v = py_v_reg;
            cy   = py_reg;
        end
        if (!fin_f_v)
        begin
            cf_v = pf_v_reg;
            cf   = pf_reg;
        end
        res            = '0;
        res.cmd_type   = fin_type;
        res.x_valid    = cx_v;
        res.x_value    = cx_v ? cx : '0;
        res.y_valid    = cy_v;
        res.y_value    = cy_v ? cy : '0;
        res.f_valid    = cf_v;
        res.feed_value = cf_v ? cf : '0;
    end

    // per-character state update
    always_comb
    begin
        mode_next  = mode_reg;
        count_next = count_reg;
        code_next  = code_reg;
        mag_next   = mag_reg;
        fcnt_next  = fcnt_reg;
        neg_next   = neg_reg;
        axis_next  = axis_reg;
        type_next  = type_reg;
        lx_v_next  = lx_v_reg;
        lx_next    = lx_reg;
        ly_v_next  = ly_v_reg;
        ly_next    = ly_reg;
        lf_v_next  = lf_v_reg;
        lf_next    = lf_reg;
        px_v_next  = px_v_reg;
        px_next    = px_reg;
        py_v_next  = py_v_reg;
        py_next    = py_reg;
        pf_v_next  = pf_v_reg;
        pf_next    = pf_reg;
        res_valid  = 1'b0;
        take_fin   = 1'b0;

        if (accept)
        begin
            if (c == CH_LF || c == CH_CR)
            begin
                if (count_reg != '0)
                begin
                    res_valid = 1'b1;
                    px_v_next = res.x_valid;
                    px_next   = res.x_value;
                    py_v_next = res.y_valid;
                    py_next   = res.y_value;
                    pf_v_next = res.f_valid;
                    pf_next   = res.feed_value;
                    count_next = '0;
                    take_fin   = 1'b1;
                end
            end
            else if (count_reg < CNT_W'(LINE_BUF - 1))
            begin
                count_next = count_reg + CNT_W'(1);
                if (mode_reg != MODE_STOPPED)
                begin
                    if (c == CH_NUL)
                    begin
                        take_fin = 1'b1;
                    end
                    else
                    begin
                        case (mode_reg)
                            MODE_CODE_G, MODE_CODE_M:
                            begin
                                if (is_digit)
                                begin
                                    code_next = (code_sum > 18'(CODE_MAX)) ? CODE_MAX
                                              : CODE_W'(code_sum);
                                end
                                else
                                begin
                                    take_fin = 1'b1;
                                end
                            end
                            MODE_NUM_START, MODE_NUM_INT:
                            begin
                                if (mode_reg == MODE_NUM_START && c == CH_MINUS)
                                begin
                                    neg_next  = 1'b1;
                                    mode_next = MODE_NUM_INT;
                                end
                                else if (is_digit)
                                begin
                                    mag_next  = (int_sum > (MAG_W+4)'(MAG_MAX)) ? MAG_MAX
                                              : MAG_W'(int_sum);
                                    mode_next = MODE_NUM_INT;
                                end
                                else if (c == CH_DOT)
                                begin
                                    mode_next = MODE_NUM_FRAC;
                                end
                                else
                                begin
                                    take_fin = 1'b1;
                                end
                            end
                            MODE_NUM_FRAC:
                            begin
                                if (is_digit)
                                begin
                                    if (fcnt_reg < FCNT_W'(FRAC_DIGITS))
                                    begin
                                        mag_next  = (frac_sum > (MAG_W+4)'(MAG_MAX))
                                                  ? MAG_MAX : MAG_W'(frac_sum);
                                        fcnt_next = fcnt_reg + FCNT_W'(1);
                                    end
                                end
                                else
                                begin
                                    take_fin = 1'b1;
                                end
                            end
                            default:
                            begin
                                take_fin = 1'b1;
                            end
                        endcase
                    end
                end
            end
            else
            begin
                // line too long: drop it
                count_next = '0;
                mode_next  = MODE_BETWEEN;
                type_next  = CMD_NONE;
                code_next  = '0;
                mag_next   = '0;
                fcnt_next  = '0;
                neg_next   = 1'b0;
                axis_next  = AXIS_X;
                lx_v_next  = 1'b0;
                ly_v_next  = 1'b0;
                lf_v_next  = 1'b0;
            end

            // apply the completed item, then a new item letter
            if (take_fin)
            begin
                mode_next = fin_mode;
                type_next = fin_type;
                lx_v_next = fin_x_v;
                lx_next   = fin_x;
                ly_v_next = fin_y_v;
                ly_next   = fin_y;
                lf_v_next = fin_f_v;
                lf_next   = fin_f;
                if (c == CH_NUL)
                begin
                    mode_next = MODE_STOPPED;
                end
                else if (fin_mode == MODE_BETWEEN && !res_valid)
                begin
                    if (c == CH_G || c == CH_M)
                    begin
                        mode_next = (c == CH_G) ? MODE_CODE_G : MODE_CODE_M;
                        code_next = '0;
                    end
                    else if (c == CH_X || c == CH_Y || c == CH_F)
                    begin
                        mode_next = MODE_NUM_START;
                        mag_next  = '0;
                        fcnt_next = '0;
                        neg_next  = 1'b0;
                        axis_next = (c == CH_X) ? AXIS_X : (c == CH_Y) ? AXIS_Y : AXIS_F;
                    end
                end
            end

            // line end clears the line
            if (res_valid)
            begin
                mode_next = MODE_BETWEEN;
                type_next = CMD_NONE;
                code_next = '0;
                mag_next  = '0;
                fcnt_next = '0;
                neg_next  = 1'b0;
                axis_next = AXIS_X;
                lx_v_next = 1'b0;
                ly_v_next = 1'b0;
                lf_v_next = 1'b0;
            end
        end
    end

    // result register and skid entry
    always_comb
    begin
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        skid_next       = skid_reg;
        skid_valid_next = skid_valid_reg;
        if (!out_valid_reg || m_tready)
        begin
            if (skid_valid_reg)
            begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_next       = res;
                out_valid_next = res_valid;
            end
        end
        else if (res_valid)
        begin
            skid_next       = res;
            skid_valid_next = 1'b1;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_BETWEEN;
            count_reg      <= '0;
            code_reg       <= '0;
            mag_reg        <= '0;
            fcnt_reg       <= '0;
            neg_reg        <= 1'b0;
            axis_reg       <= AXIS_X;
            type_reg       <= CMD_NONE;
            lx_v_reg       <= 1'b0;
            ly_v_reg       <= 1'b0;
            lf_v_reg       <= 1'b0;
            px_v_reg       <= 1'b0;
            py_v_reg       <= 1'b0;
            pf_v_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            mode_reg       <= mode_next;
            count_reg      <= count_next;
            code_reg       <= code_next;
            mag_reg        <= mag_next;
            fcnt_reg       <= fcnt_next;
            neg_reg        <= neg_next;
            axis_reg       <= axis_next;
            type_reg       <= type_next;
            lx_v_reg       <= lx_v_next;
            ly_v_reg       <= ly_v_next;
            lf_v_reg       <= lf_v_next;
            px_v_reg       <= px_v_next;
            py_v_reg       <= py_v_next;
            pf_v_reg       <= pf_v_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        lx_reg   <= lx_next;
        ly_reg   <= ly_next;
        lf_reg   <= lf_next;
        px_reg   <= px_next;
        py_reg   <= py_next;
        pf_reg   <= pf_next;
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

endmodule

// File: hdl/glp_check.sv
module glp_check (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         s_tvalid,
    input logic                         s_tready,
    input logic [7:0]                   s_tdata,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [glp_pkg::TDATA_W-1:0] m_tdata
);
    import glp_pkg::*;

    // a new command only follows a line-end beat
    a_cmd_after_eol: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready && (s_tdata == CH_LF || s_tdata == CH_CR)))
        else $error("command without a line end");

    // other characters never raise a command
    a_no_cmd_mid_line: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tdata != CH_LF && s_tdata != CH_CR && !m_tvalid)
        |=> !m_tvalid)
        else $error("command in mid line");

    // input stalls only behind a held command
    a_stall_reason: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
        else $error("input stalled with empty output");

    // absent X reads as zero, pad is zero
    a_absent_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[103:101] == 3'd0 && (m_tdata[2] || m_tdata[34:3] == 32'd0)))
        else $error("absent field or pad not zero");

    // stalled command holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("output beat changed while stalled");

endmodule

bind gcode_line_parser glp_check u_glp_check (.*);
